// ----- rtl/amdds_pkg.sv -----
// Package for the AM carrier generator: configuration register indexes, the
// queue status type and the constant functions that build the sine table.
// Has no dependencies; every other file of the block uses it by scoped names.
package amdds_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOD_DEPTH = 2'd1;

  localparam logic [31:0] PHASE_INC_RST = 32'd61847529;
  localparam logic [15:0] MOD_DEPTH_RST = 16'd29491;

  localparam int AMP_W = 17;
  localparam logic signed [AMP_W-1:0] AMP_FULL = 17'sd32768;

  // Pi in Q60, used while the sine table is built at elaboration.
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Bits [sh+63:sh] of the full 128-bit product a*b.
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  // One Taylor step divides by (k+1)*(k+2); each divisor is written out.
  function automatic logic [63:0] div_step(input logic [63:0] t, input int unsigned k);
    logic [63:0] r;
    unique case (k)
      1:  r = t / 64'd6;
      3:  r = t / 64'd20;
      5:  r = t / 64'd42;
      7:  r = t / 64'd72;
      9:  r = t / 64'd110;
      11: r = t / 64'd156;
      13: r = t / 64'd210;
      15: r = t / 64'd272;
      17: r = t / 64'd342;
      19: r = t / 64'd420;
      21: r = t / 64'd506;
      23: r = t / 64'd600;
      25: r = t / 64'd702;
      27: r = t / 64'd812;
      29: r = t / 64'd930;
      31: r = t / 64'd1056;
      33: r = t / 64'd1190;
      35: r = t / 64'd1332;
      37: r = t / 64'd1482;
      39: r = t / 64'd1640;
      41: r = t / 64'd1806;
      43: r = t / 64'd1980;
      45: r = t / 64'd2162;
      47: r = t / 64'd2352;
      49: r = t / 64'd2550;
      51: r = t / 64'd2756;
      53: r = t / 64'd2970;
      55: r = t / 64'd3192;
      57: r = t / 64'd3422;
      59: r = t / 64'd3660;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // trunc(sin(2*pi*i/2^tbits) * 32767) for a point inside the first quadrant.
  function automatic logic signed [15:0] quarter_value(input int unsigned i,
                                                       input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] scaled;
    logic        neg;
    logic        go;
    x    = mul_shr(PI_Q60, 64'(i), tbits - 1);
    x2   = mul_shr(x, x, 60);
    term = x;
    sum  = x;
    neg  = 1'b1;
    go   = 1'b1;
    for (int unsigned k = 1; k < 60; k += 2) begin
      if (go) begin
        if (term == 64'd0) begin
          go = 1'b0;
        end else begin
          term = div_step(mul_shr(term, x2, 60), k);
          if (neg) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
          neg = !neg;
        end
      end
    end
    scaled = mul_shr(sum, 64'd32767, 60);
    return scaled[15:0];
  endfunction

  // Whole-cycle table entry, built by quadrant symmetry.
  function automatic logic signed [15:0] sin_entry(input int unsigned i,
                                                   input int unsigned tbits);
    int unsigned len;
    int unsigned q;
    int unsigned h;
    logic signed [15:0] v;
    len = 32'd1 << tbits;
    q   = len >> 2;
    h   = len >> 1;
    if (i == 0 || i == h) begin
      v = 16'sd0;
    end else if (i == q) begin
      v = 16'sd32767;
    end else if (i == 3 * q) begin
      v = -16'sd32767;
    end else if (i < q) begin
      v = quarter_value(i, tbits);
    end else if (i < h) begin
      v = quarter_value(h - i, tbits);
    end else if (i < 3 * q) begin
      v = -quarter_value(i - h, tbits);
    end else begin
      v = -quarter_value(len - i, tbits);
    end
    return v;
  endfunction

endpackage

// ----- rtl/amdds_front.sv -----
// Front stage: accepts ticks, advances the phase accumulator and works out
// the new carrier amplitude. Depends on amdds_pkg.
module amdds_front #(
  parameter int TABLE_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_new_sample,
  input  logic signed [15:0]         in_audio_sample,
  input  logic [31:0]                phase_inc_i,
  input  logic [15:0]                mod_depth_i,
  input  amdds_pkg::fifo_status_t    fifo_status_i,
  output logic                       push_o,
  output logic [TABLE_BITS+amdds_pkg::AMP_W:0] push_data_o
);

  logic                                  f_valid_r;
  logic                                  f_new_r;
  logic signed [amdds_pkg::AMP_W-1:0]    f_amp_r;
  logic [TABLE_BITS-1:0]                 f_idx_r;
  logic [31:0]                           phase_acc_r;

  logic        f_rdy;
  logic        accept;
  logic [15:0] offset;
  logic [31:0] drop_prod;
  logic signed [amdds_pkg::AMP_W-1:0] amp_nxt;

  assign f_rdy    = !f_valid_r || !fifo_status_i.full;
  assign in_stall = !f_rdy;
  assign accept   = in_valid && f_rdy;
  assign push_o   = f_valid_r && !fifo_status_i.full;

  // audio + 32768 is the sample with its sign bit flipped.
  assign offset    = {~in_audio_sample[15], in_audio_sample[14:0]};
  assign drop_prod = offset * mod_depth_i;
  assign amp_nxt   = amdds_pkg::AMP_FULL - $signed({1'b0, drop_prod[31:16]});

  assign push_data_o = {f_new_r, f_amp_r, f_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r   <= 1'b0;
      phase_acc_r <= 32'd0;
    end else begin
      if (f_rdy) begin
        f_valid_r <= in_valid;
      end
      if (accept) begin
        phase_acc_r <= phase_acc_r + phase_inc_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_new_r <= in_new_sample;
      f_amp_r <= amp_nxt;
      f_idx_r <= phase_acc_r[31 -: TABLE_BITS];
    end
  end

  a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> phase_acc_r == $past(phase_acc_r) + $past(phase_inc_i))
    else $error("phase accumulator did not advance by the step");

endmodule

// ----- rtl/amdds_fifo.sv -----
// Short queue between the front and back stages.
// Depends on amdds_pkg for the status struct.
module amdds_fifo #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_i,
  input  logic [WIDTH-1:0]        push_data_i,
  input  logic                    pop_i,
  output logic [WIDTH-1:0]        pop_data_o,
  output amdds_pkg::fifo_status_t status_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign status_o.full  = (count_r == CW'(DEPTH));
  assign status_o.empty = (count_r == '0);
  assign pop_data_o     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && status_o.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && status_o.empty))
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- rtl/amdds_back.sv -----
// Back stages: carrier amplitude state, sine table lookup, scaling multiply
// and the output register. Depends on amdds_pkg for the table and types.
module amdds_back #(
  parameter int TABLE_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  amdds_pkg::fifo_status_t    fifo_status_i,
  input  logic [TABLE_BITS+amdds_pkg::AMP_W:0] pop_data_i,
  output logic                       pop_o,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [6:0]          out_dac_sample
);

  localparam int ROM_LEN = 1 << TABLE_BITS;
  localparam int AW      = amdds_pkg::AMP_W;

  logic signed [15:0] sin_rom [ROM_LEN];

  for (genvar g = 0; g < ROM_LEN; g++) begin : g_rom
    localparam logic signed [15:0] ROM_ENTRY = amdds_pkg::sin_entry(g, TABLE_BITS);
    assign sin_rom[g] = ROM_ENTRY;
  end

  logic                    e_new;
  logic signed [AW-1:0]    e_amp;
  logic [TABLE_BITS-1:0]   e_idx;

  logic signed [AW-1:0]    carrier_amp_r;
  logic                    b1_valid_r;
  logic signed [AW-1:0]    b1_amp_r;
  logic signed [15:0]      b1_rom_r;
  logic                    b2_valid_r;
  logic signed [32:0]      prod_r;
  logic                    out_valid_r;
  logic signed [6:0]       dac_r;

  logic                    rdy1;
  logic                    rdy2;
  logic                    rdy3;
  logic signed [AW-1:0]    amp_cur;
  logic signed [32:0]      prod_nxt;

  assign {e_new, e_amp, e_idx} = pop_data_i;

  assign rdy3  = !out_valid_r || !out_stall;
  assign rdy2  = !b2_valid_r || rdy3;
  assign rdy1  = !b1_valid_r || rdy2;
  assign pop_o = !fifo_status_i.empty && rdy1;

  assign amp_cur  = (pop_o && e_new) ? e_amp : carrier_amp_r;
  assign prod_nxt = 33'(b1_amp_r) * 33'(b1_rom_r);

  assign out_valid      = out_valid_r;
  assign out_dac_sample = dac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_amp_r <= amdds_pkg::AMP_FULL;
      b1_valid_r    <= 1'b0;
      b2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop_o) begin
        carrier_amp_r <= amp_cur;
      end
      if (rdy1) begin
        b1_valid_r <= pop_o;
      end
      if (rdy2) begin
        b2_valid_r <= b1_valid_r;
      end
      if (rdy3) begin
        out_valid_r <= b2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      b1_amp_r <= amp_cur;
      b1_rom_r <= sin_rom[e_idx];
    end
    if (rdy2 && b1_valid_r) begin
      prod_r <= prod_nxt;
    end
    if (rdy3 && b2_valid_r) begin
      dac_r <= prod_r[30:24];
    end
  end

endmodule

// ----- rtl/am_dds_modulator.sv -----
// Top level of the AM carrier generator: configuration registers and the
// front stage, queue and back stages. Depends on amdds_pkg and its modules.
//
// Usage: each input beat on in_valid/in_stall is one DAC tick. When
// in_new_sample is high the beat carries a fresh audio sample, which sets a
// new carrier amplitude from the modulation depth; otherwise the amplitude is
// kept. Every tick gives exactly one output beat on out_valid/out_stall with
// the signed 7-bit DAC sample: the sine table entry picked by the top phase
// bits, scaled by the amplitude. The phase then advances by the increment.
// An accepted input beat passes the front register, one queue slot, the
// table read register and the multiply register ahead of the output
// register, which drives out_valid; one beat per cycle is sustained when
// the receiver does not stall.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata):
// index 0 is the phase increment, index 1 the modulation depth, others are
// ignored. Reset clears the phase to zero, sets full amplitude and loads the
// default increment and depth; the sine table is constant, so no clearing.
// When the receiver stalls, the back stages hold, the queue fills, and then
// in_stall rises until the output moves again; no beat is lost.
module am_dds_modulator #(
  parameter int TABLE_BITS = 8,
  parameter int FIFO_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_new_sample,
  input  logic signed [15:0]                   in_audio_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [6:0]                    out_dac_sample,
  input  logic                                 cfg_wr_en,
  input  logic [amdds_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [amdds_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // One queue entry: new-sample flag, amplitude and table index.
  localparam int ENTRY_W = 1 + amdds_pkg::AMP_W + TABLE_BITS;

  logic [31:0] phase_inc_r;
  logic [15:0] mod_depth_r;

  logic                     push;
  logic                     pop;
  logic [ENTRY_W-1:0]       push_data;
  logic [ENTRY_W-1:0]       pop_data;
  amdds_pkg::fifo_status_t  fifo_status;

  // Register writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= amdds_pkg::PHASE_INC_RST;
      mod_depth_r <= amdds_pkg::MOD_DEPTH_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == amdds_pkg::REG_PHASE_INC) begin
        phase_inc_r <= cfg_wdata[31:0];
      end
      if (cfg_index == amdds_pkg::REG_MOD_DEPTH) begin
        mod_depth_r <= cfg_wdata[15:0];
      end
    end
  end

  amdds_front #(
    .TABLE_BITS (TABLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_new_sample   (in_new_sample),
    .in_audio_sample (in_audio_sample),
    .phase_inc_i     (phase_inc_r),
    .mod_depth_i     (mod_depth_r),
    .fifo_status_i   (fifo_status),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  amdds_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_status)
  );

  amdds_back #(
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_status_i  (fifo_status),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dac_sample (out_dac_sample)
  );

endmodule

// ----- dv/am_dds_checker.sv -----
// Scoreboard for the AM carrier generator: keeps its own phase, amplitude and
// sine table, predicts each DAC sample and compares it with the output beats.
// Depends on amdds_pkg for register indexes, reset values and port widths.
module am_dds_checker #(
  parameter int TABLE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_new_sample,
  input  logic signed [15:0]                in_audio_sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [6:0]                 out_dac_sample,
  input  logic                              cfg_wr_en,
  input  logic [amdds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [amdds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                mismatch_count,
  output int                                pending
);

  localparam int  TABLE_LEN = 1 << TABLE_BITS;
  localparam real TWO_PI    = 6.283185307179586476925;

  logic signed [15:0] sine_rom [TABLE_LEN];

  logic [31:0]        phase_inc;
  logic [15:0]        mod_depth;
  logic [31:0]        phase_acc;
  logic signed [16:0] carrier_amp;

  logic signed [6:0]  dac_expected [$];
  int                 error_total;
  int                 results_seen;

  // One table entry: the first quadrant is computed, the rest mirrored, so
  // the symmetry of the table is exact.
  function automatic logic signed [15:0] sine_point(input int i);
    int                 q;
    int                 h;
    int                 m;
    logic signed [15:0] mag;
    q = TABLE_LEN / 4;
    h = TABLE_LEN / 2;
    if (i == 0 || i == h) return 16'sd0;
    if (i == q) return 16'sd32767;
    if (i == 3 * q) return -16'sd32767;
    if (i < q) m = i;
    else if (i < h) m = h - i;
    else if (i < 3 * q) m = i - h;
    else m = TABLE_LEN - i;
    mag = 16'($rtoi($sin(TWO_PI * m / TABLE_LEN) * 32767.0));
    return (i < h) ? mag : -mag;
  endfunction

  // Advances the oscillator by one tick and returns the DAC sample it gives.
  function automatic logic signed [6:0] dds_tick(input logic new_sample,
                                                 input logic [15:0] audio);
    logic [31:0]           drop_full;
    logic [TABLE_BITS-1:0] idx;
    longint                scaled;
    if (new_sample) begin
      drop_full   = 32'(audio ^ 16'h8000) * 32'(mod_depth);
      carrier_amp = 17'(32768 - int'(drop_full[31:16]));
    end
    idx       = phase_acc[31 -: TABLE_BITS];
    phase_acc = phase_acc + phase_inc;
    scaled    = longint'(carrier_amp) * longint'(sine_rom[idx]);
    return 7'(scaled >>> 24);
  endfunction

  initial begin
    for (int i = 0; i < TABLE_LEN; i++) sine_rom[i] = sine_point(i);
    error_total  = 0;
    results_seen = 0;
  end

  assign mismatch_count = error_total;

  always @(posedge clk) begin
    if (!rst_n) begin
      phase_inc   = amdds_pkg::PHASE_INC_RST;
      mod_depth   = amdds_pkg::MOD_DEPTH_RST;
      phase_acc   = '0;
      carrier_amp = amdds_pkg::AMP_FULL;
      dac_expected.delete();
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          amdds_pkg::REG_PHASE_INC: phase_inc = cfg_wdata[31:0];
          amdds_pkg::REG_MOD_DEPTH: mod_depth = cfg_wdata[15:0];
          default: ;
        endcase
      end
      // The output is taken first so that a beat leaving on the same edge as
      // a new input beat cannot be matched against that input.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (dac_expected.size() == 0) begin
          if (error_total < 10)
            $display("unexpected dac_sample %0d at result %0d", out_dac_sample,
                     results_seen);
          error_total++;
        end else begin
          if (out_dac_sample !== dac_expected[0]) begin
            if (error_total < 10)
              $display("dac_sample mismatch at result %0d: expected %0d, got %0d",
                       results_seen, dac_expected[0], out_dac_sample);
            error_total++;
          end
          void'(dac_expected.pop_front());
        end
      end
      if (in_valid && !in_stall)
        dac_expected.push_back(dds_tick(in_new_sample, in_audio_sample));
    end
    pending <= dac_expected.size();
  end

endmodule

// ----- dv/am_dds_modulator_test.sv -----
// Top of the AM carrier generator testbench: clock, reset, configuration and
// tick stimulus, random stalls and the verdict. Depends on amdds_pkg, the
// block am_dds_modulator and the scoreboard am_dds_checker.
module am_dds_modulator_test;

  localparam int TABLE_BITS      = 8;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 200;
  // Every tick gives a beat, so a correct run is never quiet for long: the
  // worst is a run of sender idles or receiver stalls at 49 in a hundred, or
  // the short idle stretches around register writes and the final pause.
  localparam int WATCHDOG_LIMIT  = 2000;
  // A margin past the block's latency, before the verdict.
  localparam int DRAIN_CYCLES    = 16;

  // Indexes the block has no register for; writes to them must change nothing.
  localparam logic [amdds_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [amdds_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                              clk             = 1'b0;
  logic                              rst_n           = 1'b0;
  logic                              in_valid        = 1'b0;
  logic                              in_stall;
  logic                              in_new_sample   = 1'b0;
  logic signed [15:0]                in_audio_sample = '0;
  logic                              out_valid;
  logic                              out_stall       = 1'b0;
  logic signed [6:0]                 out_dac_sample;
  logic                              cfg_wr_en       = 1'b0;
  logic [amdds_pkg::CFG_INDEX_W-1:0] cfg_index       = '0;
  logic [amdds_pkg::CFG_DATA_W-1:0]  cfg_wdata       = '0;

  int mismatch_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  always #2 clk = ~clk;

  am_dds_modulator #(
    .TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_new_sample  (in_new_sample),
    .in_audio_sample(in_audio_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dac_sample (out_dac_sample),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  am_dds_checker #(
    .TABLE_BITS(TABLE_BITS)
  ) scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_new_sample  (in_new_sample),
    .in_audio_sample(in_audio_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dac_sample (out_dac_sample),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // The receiver decides afresh on every edge whether to hold off the next
  // output beat, so stalls land on every stage of the pipeline.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a stretch with no beat moving on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("am_dds_modulator test failed");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    unique case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 49;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 49;
      end
      default: begin
        send_idle_pct  = 20;
        recv_stall_pct = 20;
      end
    endcase
  endtask

  // Offers one tick and returns on the edge that accepts it. Valid is left
  // high, so back-to-back ticks never lower and raise it in one time step;
  // it only drops for a random idle cycle or when the sender pauses.
  task automatic send_tick(input logic new_sample, input logic [15:0] audio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_new_sample   <= new_sample;
    in_audio_sample <= audio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The sender stops and waits until every predicted sample has come out.
  // The first edge lets the scoreboard count the last tick that was taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write enable stays high across a run of writes; the caller lowers it.
  task automatic write_reg(input logic [amdds_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] step_val;
    logic [15:0] mod_val;
    logic [15:0] audio;
    int          new_pct;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, no idling. Full-scale audio both ways, zero and minus
    // one, and ticks without a new sample whose audio must be ignored.
    set_idle(IDLE_NONE);
    send_tick(1'b1, 16'h8000);
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'h5555);
    send_tick(1'b0, 16'hAAAA);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'h7FFF);
    send_tick(1'b0, 16'h8000);

    // A quarter-turn step moves the table index on by a quarter of the table
    // with each tick. The largest depth drives the amplitude negative, to
    // its lowest value, when the audio is at its top. The unused indexes get
    // written as well and must leave no trace.
    drain();
    write_reg(amdds_pkg::REG_PHASE_INC, 32'h4000_0000);
    write_reg(amdds_pkg::REG_MOD_DEPTH, 32'h0000_FFFF);
    write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED_HI, 32'h0000_0001);
    cfg_wr_en <= 1'b0;
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b0, 16'h1234);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'h8000);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'h0000);

    // Largest step, which walks the phase backwards, with no modulation.
    drain();
    write_reg(amdds_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
    write_reg(amdds_pkg::REG_MOD_DEPTH, 32'h0000_0000);
    cfg_wr_en <= 1'b0;
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b1, 16'h8000);
    send_tick(1'b0, 16'h0001);

    // Depth exactly one: the amplitude falls to one at the top of the audio.
    drain();
    write_reg(amdds_pkg::REG_PHASE_INC, 32'h0100_0000);
    write_reg(amdds_pkg::REG_MOD_DEPTH, 32'h0000_8000);
    cfg_wr_en <= 1'b0;
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'h8000);
    send_tick(1'b1, 16'hC000);

    // Random phases. Each one sets its own step and depth, with the extremes
    // among them, and its own share of ticks that bring a new sample. The
    // upper half of the depth write carries junk that must be dropped. Half
    // way through every phase the sender pauses until the pipe is empty.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0:       step_val = 32'h0100_0000;
        1:       step_val = 32'h0000_0000;
        2:       step_val = 32'hFFFF_FFFF;
        default: step_val = $urandom;
      endcase
      case (p)
        3:       mod_val = 16'hFFFF;
        5:       mod_val = 16'h0000;
        6:       mod_val = 16'h8000;
        7:       mod_val = 16'($urandom_range(65535, 32769));
        default: mod_val = 16'($urandom_range(32768));
      endcase
      write_reg(amdds_pkg::REG_PHASE_INC, step_val);
      write_reg(amdds_pkg::REG_MOD_DEPTH, {16'($urandom), mod_val});
      cfg_wr_en <= 1'b0;
      set_idle(idle_mode_t'(p % 4));
      new_pct = $urandom_range(95, 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain();
        if ($urandom_range(7) == 0) begin
          audio = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        end else begin
          audio = 16'($urandom);
        end
        send_tick($urandom_range(99) < new_pct, audio);
      end
    end

    // Wait for the last sample, then a few cycles more so that any stray
    // extra beat from the block is seen by the scoreboard.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("am_dds_modulator test passed");
    end else begin
      $display("am_dds_modulator test failed");
    end
    $finish;
  end

endmodule
